@@ hw/rtl/psa_pkg.sv @@
// Shared types, constants and codes of the page stack allocator.
package psa_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int FRAME_AW   = $clog2(MAX_FRAMES);
  localparam int DEPTH_W    = FRAME_AW + 1;

  localparam int ADDR_W  = 64;
  localparam int LEN_W   = 41;
  localparam int SHIFT_W = 5;
  localparam int ELEM_W  = 32;
  localparam int PROD_W  = 2 * ELEM_W;

  // The link word that precedes every frame.
  localparam logic [PROD_W:0] LINK_BYTES = (PROD_W + 1)'(8);

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT    = 2'd2;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [ELEM_W-1:0] element_size;
    logic [ELEM_W-1:0] element_count;
  } psa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] cursor_address;
    logic [LEN_W-1:0]  free_bytes;
  } psa_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new item and form its product
    logic commit;  // apply the item to the stack and latch its result
  } psa_cmd_t;

endpackage

@@ hw/rtl/psa_ctrl.sv @@
// Controller of the page stack allocator: item sequencing and handshakes.
module psa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output psa_pkg::psa_cmd_t cmd
);
  import psa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // The result slot can take a new result when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/psa_dp.sv @@
// Datapath of the page stack allocator: configuration, cursor, frame store and rounding.
module psa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psa_pkg::psa_cmd_t            cmd,
  input  psa_pkg::psa_in_t             in_data,
  input  logic                         cfg_we,
  input  logic [psa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psa_pkg::ADDR_W-1:0]   cfg_data,
  output psa_pkg::psa_out_t            out_data
);
  import psa_pkg::*;

  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [LEN_W-1:0]   cursor_r, cursor_nxt;
  logic [ADDR_W-1:0]  cur_addr_r, cur_addr_nxt;
  logic [LEN_W-1:0]   free_r, free_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [ADDR_W-1:0]  block_r, block_nxt;

  logic               op_r;
  logic [PROD_W-1:0]  product_r;

  logic [LEN_W-1:0]   frames [MAX_FRAMES];
  logic [LEN_W-1:0]   rd_len_r;
  logic [FRAME_AW-1:0] rd_idx;
  logic               frame_we;

  logic [PROD_W:0]    page_mask;
  logic [PROD_W:0]    len_up;
  logic [PROD_W:0]    aligned;
  logic               overflow;
  logic               fits;
  logic               full;
  logic               empty;
  logic [LEN_W:0]     pop_diff;
  logic [LEN_W-1:0]   pop_cursor;
  logic [LEN_W:0]     free_diff;
  logic [LEN_W:0]     cfg_free_diff;

  // Round product plus link word up to whole pages in one wider add; a carry
  // into the top bit means the rounded length passed the 64-bit range.
  assign page_mask = ((PROD_W + 1)'(1) << shift_r) - (PROD_W + 1)'(1);
  assign len_up    = {1'b0, product_r} + LINK_BYTES + page_mask;
  assign aligned   = len_up & ~page_mask;
  assign overflow  = aligned[PROD_W];
  assign fits      = (aligned[PROD_W:LEN_W] == '0) && (aligned[LEN_W-1:0] <= free_r);
  assign full      = (depth_r == DEPTH_W'(MAX_FRAMES));
  assign empty     = (depth_r == '0);

  assign pop_diff   = {1'b0, cursor_r} - {1'b0, rd_len_r};
  assign pop_cursor = pop_diff[LEN_W] ? '0 : pop_diff[LEN_W-1:0];
  assign free_diff  = {1'b0, length_r} - {1'b0, pop_cursor};
  assign cfg_free_diff = {1'b0, cfg_data[LEN_W-1:0]} - {1'b0, cursor_r};

  assign rd_idx   = depth_r[FRAME_AW-1:0] - FRAME_AW'(1);
  assign frame_we = cmd.commit && (op_r == OP_PUSH) && !overflow && !full && fits;

  always_comb begin
    base_nxt     = base_r;
    length_nxt   = length_r;
    shift_nxt    = shift_r;
    cursor_nxt   = cursor_r;
    cur_addr_nxt = cur_addr_r;
    free_nxt     = free_r;
    depth_nxt    = depth_r;
    status_nxt   = status_r;
    block_nxt    = block_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_BASE: begin
          base_nxt     = cfg_data;
          cursor_nxt   = '0;
          cur_addr_nxt = cfg_data;
          depth_nxt    = '0;
          free_nxt     = length_r;
        end
        CFG_REGION_LENGTH: begin
          length_nxt = cfg_data[LEN_W-1:0];
          free_nxt   = cfg_free_diff[LEN_W] ? '0 : cfg_free_diff[LEN_W-1:0];
        end
        CFG_PAGE_SHIFT: begin
          shift_nxt = cfg_data[SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end

    if (cmd.commit) begin
      block_nxt = '0;
      if (op_r == OP_PUSH) begin
        if (overflow) begin
          status_nxt = ST_OVERFLOW;
        end else if (full || !fits) begin
          status_nxt = ST_NO_SPACE;
        end else begin
          status_nxt   = ST_OK;
          block_nxt    = cur_addr_r;
          cursor_nxt   = cursor_r + aligned[LEN_W-1:0];
          cur_addr_nxt = cur_addr_r + ADDR_W'(aligned[LEN_W-1:0]);
          free_nxt     = free_r - aligned[LEN_W-1:0];
          depth_nxt    = depth_r + DEPTH_W'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt   = ST_OK;
          cursor_nxt   = pop_cursor;
          cur_addr_nxt = pop_diff[LEN_W] ? base_r : (cur_addr_r - ADDR_W'(rd_len_r));
          free_nxt     = free_diff[LEN_W] ? '0 : free_diff[LEN_W-1:0];
          depth_nxt    = depth_r - DEPTH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      length_r   <= '0;
      shift_r    <= SHIFT_RESET;
      cursor_r   <= '0;
      cur_addr_r <= '0;
      free_r     <= '0;
      depth_r    <= '0;
    end else begin
      base_r     <= base_nxt;
      length_r   <= length_nxt;
      shift_r    <= shift_nxt;
      cursor_r   <= cursor_nxt;
      cur_addr_r <= cur_addr_nxt;
      free_r     <= free_nxt;
      depth_r    <= depth_nxt;
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_data.operation;
      product_r <= PROD_W'(in_data.element_size) * PROD_W'(in_data.element_count);
    end
    status_r <= status_nxt;
    block_r  <= block_nxt;
  end

  // Frame store: one write port, one registered read of the newest frame.
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frames[depth_r[FRAME_AW-1:0]] <= aligned[LEN_W-1:0];
    end
    rd_len_r <= frames[rd_idx];
  end

  // Cursor address and free bytes change only at a commit or a configuration
  // write, so the live registers serve as the held result.
  assign out_data.status         = status_r;
  assign out_data.block_address  = block_r;
  assign out_data.cursor_address = cur_addr_r;
  assign out_data.free_bytes     = free_r;

endmodule

@@ hw/rtl/page_stack_allocator.sv @@
// Page stack allocator: pushes and pops page-rounded frames over one address region.
//
// Input channel in_valid / in_stall / in_data carries one request item: a push
// (element size and count) or a pop. Result channel out_valid / out_stall /
// out_data returns exactly one item per request: status, block address,
// cursor address and free bytes after the operation.
// The configuration port (cfg_we, cfg_index, cfg_data) writes region base,
// region length and page shift; the user must write it only while no item is
// in flight, which the block itself does not enforce. Writing the region base
// moves the cursor to the base and empties the stack. An item is captured and
// its 32 x 32 product formed, then it is rounded, checked against the free space
// and applied to the stack once the result slot is free. Items are taken one at a time.
// The next item is accepted while a finished result is still waiting.
// When the receiver stalls, the result holds and the block takes at most
// one more item, which then waits in execution until the result slot drains.
// Reset (rst_n low, synchronous) empties the stack, clears base and length
// and sets the page shift to 12. No clearing pass is needed.
module page_stack_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  psa_pkg::psa_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output psa_pkg::psa_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [psa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psa_pkg::ADDR_W-1:0]   cfg_data
);
  import psa_pkg::*;

  psa_cmd_t cmd;

  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  psa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  // An accepted item keeps the input closed while it is in execution.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after an item");

  // A failed operation never hands out a block.
  a_no_block_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.block_address == '0))
    else $error("block address given with an error status");

  // A new result only appears after an item was in execution.
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in execution");

endmodule
